@@ rtl/mtq_pkg.sv @@
// Shared types, codes and constants of the multi-timer expiry queue.
package mtq_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int DEF_ID_BITS     = 8;
  localparam int TIMER_ID_W      = 8;
  localparam int DELAY_W         = 40;
  localparam int ELAPSED_W       = 32;
  localparam int FIRED_ID_W      = 8;

  typedef struct packed {
    logic                  mode;
    logic [TIMER_ID_W-1:0] timer_id;
    logic [DELAY_W-1:0]    delay_us;
    logic [ELAPSED_W-1:0]  elapsed_us;
  } in_item_t;

  typedef struct packed {
    logic                  fired_valid;
    logic [FIRED_ID_W-1:0] fired_id;
    logic                  last;
    logic                  status;
  } out_item_t;

  typedef enum logic {
    MODE_ARM  = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    WALK_SCAN,
    WALK_AGE,
    WALK_FIX
  } walk_op_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_ACK,
    EMIT_FULL,
    EMIT_FIRE
  } emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ARM_SCAN,
    ST_ARM_FIX,
    ST_TICK_AGE,
    ST_TICK_PICK,
    ST_TICK_CLOSE
  } state_t;

  typedef struct packed {
    logic     capture;
    logic     walk_go;
    walk_op_t walk_op;
    logic     search;
    logic     cancel_match;
    logic     rank_match;
    logic     write_rearm;
    logic     write_new;
    emit_t    emit;
  } mtq_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic delay_zero;
    logic match_hit;
    logic free_hit;
    logic exp_any;
    logic exp_last;
  } mtq_stat_t;

endpackage

@@ rtl/mtq_ctrl.sv @@
// Sequencer of the timer queue: orders the slot walks, writes and results.
module mtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  mtq_pkg::mtq_stat_t  stat,
  output mtq_pkg::mtq_cmd_t   cmd,
  output logic                busy
);

  mtq_pkg::state_t state;
  mtq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mtq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mtq_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (mode == mtq_pkg::MODE_TICK) ? mtq_pkg::ST_TICK_AGE
                                                    : mtq_pkg::ST_ARM_SCAN;
        end
      end
      mtq_pkg::ST_ARM_SCAN: begin
        if (stat.walk_done) begin
          state_next = stat.match_hit ? mtq_pkg::ST_ARM_FIX : mtq_pkg::ST_IDLE;
        end
      end
      mtq_pkg::ST_ARM_FIX: begin
        if (stat.walk_done) begin
          state_next = mtq_pkg::ST_IDLE;
        end
      end
      mtq_pkg::ST_TICK_AGE: begin
        if (stat.walk_done) begin
          state_next = stat.exp_any ? mtq_pkg::ST_TICK_PICK : mtq_pkg::ST_IDLE;
        end
      end
      mtq_pkg::ST_TICK_PICK: begin
        if (stat.walk_done && stat.exp_last) begin
          state_next = mtq_pkg::ST_TICK_CLOSE;
        end
      end
      mtq_pkg::ST_TICK_CLOSE: begin
        if (stat.walk_done) begin
          state_next = mtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.walk_op = mtq_pkg::WALK_FIX;
    cmd.emit = mtq_pkg::EMIT_NONE;
    case (state)
      mtq_pkg::ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          cmd.walk_go = 1'b1;
          cmd.walk_op = (mode == mtq_pkg::MODE_TICK) ? mtq_pkg::WALK_AGE
                                                     : mtq_pkg::WALK_SCAN;
        end
      end
      mtq_pkg::ST_ARM_SCAN: begin
        if (stat.walk_done) begin
          if (stat.match_hit) begin
            // close up the ranks behind the matched timer
            cmd.walk_go = 1'b1;
            cmd.rank_match = 1'b1;
            cmd.cancel_match = stat.delay_zero;
          end else if (stat.delay_zero) begin
            cmd.emit = mtq_pkg::EMIT_ACK;
          end else if (!stat.free_hit) begin
            cmd.emit = mtq_pkg::EMIT_FULL;
          end else begin
            cmd.write_new = 1'b1;
            cmd.emit = mtq_pkg::EMIT_ACK;
          end
        end
      end
      mtq_pkg::ST_ARM_FIX: begin
        if (stat.walk_done) begin
          cmd.write_rearm = !stat.delay_zero;
          cmd.emit = mtq_pkg::EMIT_ACK;
        end
      end
      mtq_pkg::ST_TICK_AGE: begin
        if (stat.walk_done) begin
          if (stat.exp_any) begin
            cmd.walk_go = 1'b1;
            cmd.search = 1'b1;
          end else begin
            cmd.emit = mtq_pkg::EMIT_ACK;
          end
        end
      end
      mtq_pkg::ST_TICK_PICK: begin
        if (stat.walk_done) begin
          cmd.emit = mtq_pkg::EMIT_FIRE;
          cmd.walk_go = 1'b1;
          cmd.search = !stat.exp_last;
        end
      end
      mtq_pkg::ST_TICK_CLOSE: begin
      end
      default: begin
      end
    endcase
  end

  assign busy = (state != mtq_pkg::ST_IDLE);

endmodule

@@ rtl/mtq_dp.sv @@
// Datapath of the timer queue: slot stores, walk engine and result register.
module mtq_dp #(
  parameter int TIMER_SLOTS = mtq_pkg::DEF_TIMER_SLOTS,
  parameter int ID_BITS     = mtq_pkg::DEF_ID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  mtq_pkg::in_item_t   request,
  input  mtq_pkg::mtq_cmd_t   cmd,
  output mtq_pkg::mtq_stat_t  stat,
  output logic                result_valid,
  output mtq_pkg::out_item_t  result
);

  localparam int SLOT_BITS = $clog2(TIMER_SLOTS);
  localparam int CNT_BITS  = $clog2(TIMER_SLOTS + 1);
  localparam int DW        = mtq_pkg::DELAY_W;
  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(TIMER_SLOTS - 1);

  // slot stores: one read and one write address per cycle
  logic [ID_BITS-1:0]   id_mem  [TIMER_SLOTS];
  logic [DW-1:0]        rem_mem [TIMER_SLOTS];
  logic [SLOT_BITS-1:0] ord_mem [TIMER_SLOTS];

  mtq_pkg::in_item_t    req;
  logic [ID_BITS-1:0]   req_id;
  logic [DW-1:0]        elapsed_ext;

  logic [TIMER_SLOTS-1:0] used;
  logic [TIMER_SLOTS-1:0] expired;

  logic                 walk_run;
  mtq_pkg::walk_op_t    walk_op;
  logic                 search_on;
  logic [SLOT_BITS-1:0] idx;
  logic                 rd_live;
  logic [SLOT_BITS-1:0] rd_slot;
  logic [ID_BITS-1:0]   rd_id;
  logic [DW-1:0]        rd_rem;
  logic [SLOT_BITS-1:0] rd_ord;
  logic                 done_q;

  logic                 match_hit;
  logic [SLOT_BITS-1:0] match_slot;
  logic [SLOT_BITS-1:0] match_ord;
  logic                 free_hit;
  logic [SLOT_BITS-1:0] free_slot;
  logic [CNT_BITS-1:0]  used_cnt;
  logic [CNT_BITS-1:0]  exp_cnt;
  logic                 rank_en;
  logic [SLOT_BITS-1:0] rank_ord;
  logic                 best_hit;
  logic [SLOT_BITS-1:0] best_slot;
  logic [ID_BITS-1:0]   best_id;
  logic [DW-1:0]        best_rem;
  logic [SLOT_BITS-1:0] best_ord;

  logic                 live_used;
  logic                 age_fire;
  logic                 ord_dec;
  logic [SLOT_BITS-1:0] ord_post;
  logic                 cand;

  logic                 we_id;
  logic                 we_rem;
  logic                 we_ord;
  logic [SLOT_BITS-1:0] waddr;
  logic [DW-1:0]        wrem;
  logic [SLOT_BITS-1:0] word;

  assign req_id      = ID_BITS'(req.timer_id);
  assign elapsed_ext = DW'(req.elapsed_us);

  // per-slot evaluation of the record read back in this cycle
  assign live_used = used[rd_slot];
  assign age_fire  = live_used && (rd_rem <= elapsed_ext);
  assign ord_dec   = rank_en && live_used && (rd_ord > rank_ord);
  assign ord_post  = ord_dec ? (rd_ord - 1'b1) : rd_ord;
  // ranks shift uniformly, so post-shift ranks compare like the old ones
  assign cand      = search_on && expired[rd_slot] &&
                     (!best_hit || (rd_rem < best_rem) ||
                      ((rd_rem == best_rem) && (ord_post < best_ord)));

  always_comb begin
    we_id  = 1'b0;
    we_rem = 1'b0;
    we_ord = 1'b0;
    waddr  = rd_slot;
    wrem   = req.delay_us;
    word   = ord_post;
    if (rd_live && (walk_op == mtq_pkg::WALK_AGE) && live_used && !age_fire) begin
      we_rem = 1'b1;
      wrem   = rd_rem - elapsed_ext;
    end else if (rd_live && (walk_op == mtq_pkg::WALK_FIX) && ord_dec) begin
      we_ord = 1'b1;
    end else if (cmd.write_rearm) begin
      we_id  = 1'b1;
      we_rem = 1'b1;
      we_ord = 1'b1;
      waddr  = match_slot;
      word   = SLOT_BITS'(used_cnt - 1'b1);
    end else if (cmd.write_new) begin
      we_id  = 1'b1;
      we_rem = 1'b1;
      we_ord = 1'b1;
      waddr  = free_slot;
      word   = SLOT_BITS'(used_cnt);
    end
  end

  always_ff @(posedge clk) begin
    if (we_id) begin
      id_mem[waddr] <= req_id;
    end
    if (we_rem) begin
      rem_mem[waddr] <= wrem;
    end
    if (we_ord) begin
      ord_mem[waddr] <= word;
    end
    if (walk_run) begin
      rd_id  <= id_mem[idx];
      rd_rem <= rem_mem[idx];
      rd_ord <= ord_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
    end
    if (cmd.walk_go) begin
      walk_op   <= cmd.walk_op;
      search_on <= cmd.search;
      idx       <= '0;
    end else if (walk_run && (idx != LAST_SLOT)) begin
      idx <= idx + 1'b1;
    end
    rd_slot <= idx;
  end

  // walk sequencing: address issue, read-back, end-of-walk pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_run <= 1'b0;
      rd_live  <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      if (cmd.walk_go) begin
        walk_run <= 1'b1;
      end else if (walk_run && (idx == LAST_SLOT)) begin
        walk_run <= 1'b0;
      end
      rd_live <= walk_run;
      done_q  <= rd_live && (rd_slot == LAST_SLOT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      expired   <= '0;
      rank_en   <= 1'b0;
      match_hit <= 1'b0;
      free_hit  <= 1'b0;
      best_hit  <= 1'b0;
      used_cnt  <= '0;
      exp_cnt   <= '0;
    end else begin
      if (cmd.capture) begin
        rank_en <= 1'b0;
      end
      if (cmd.walk_go) begin
        case (cmd.walk_op)
          mtq_pkg::WALK_SCAN: begin
            match_hit <= 1'b0;
            free_hit  <= 1'b0;
            used_cnt  <= '0;
          end
          mtq_pkg::WALK_AGE: begin
            exp_cnt <= '0;
            expired <= '0;
          end
          mtq_pkg::WALK_FIX: begin
            best_hit <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (rd_live) begin
        case (walk_op)
          mtq_pkg::WALK_SCAN: begin
            if (live_used) begin
              used_cnt <= used_cnt + 1'b1;
              if (!match_hit && (rd_id == req_id)) begin
                match_hit  <= 1'b1;
                match_slot <= rd_slot;
                match_ord  <= rd_ord;
              end
            end else if (!free_hit) begin
              free_hit  <= 1'b1;
              free_slot <= rd_slot;
            end
          end
          mtq_pkg::WALK_AGE: begin
            if (age_fire) begin
              expired[rd_slot] <= 1'b1;
              exp_cnt <= exp_cnt + 1'b1;
            end
          end
          mtq_pkg::WALK_FIX: begin
            if (cand) begin
              best_hit  <= 1'b1;
              best_slot <= rd_slot;
              best_id   <= rd_id;
              best_rem  <= rd_rem;
              best_ord  <= ord_post;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.rank_match) begin
        rank_en  <= 1'b1;
        rank_ord <= match_ord;
      end
      if (cmd.cancel_match) begin
        used[match_slot] <= 1'b0;
      end
      if (cmd.write_new) begin
        used[free_slot] <= 1'b1;
      end
      if (cmd.emit == mtq_pkg::EMIT_FIRE) begin
        used[best_slot]    <= 1'b0;
        expired[best_slot] <= 1'b0;
        exp_cnt  <= exp_cnt - 1'b1;
        rank_en  <= 1'b1;
        rank_ord <= best_ord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.emit != mtq_pkg::EMIT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.emit)
      mtq_pkg::EMIT_FIRE: begin
        result.fired_valid <= 1'b1;
        result.fired_id    <= mtq_pkg::FIRED_ID_W'(best_id);
        result.last        <= (exp_cnt == CNT_BITS'(1));
        result.status      <= 1'b0;
      end
      mtq_pkg::EMIT_FULL: begin
        result.fired_valid <= 1'b0;
        result.fired_id    <= '0;
        result.last        <= 1'b1;
        result.status      <= 1'b1;
      end
      default: begin
        result.fired_valid <= 1'b0;
        result.fired_id    <= '0;
        result.last        <= 1'b1;
        result.status      <= 1'b0;
      end
    endcase
  end

  assign stat.walk_done  = done_q;
  assign stat.delay_zero = (req.delay_us == '0);
  assign stat.match_hit  = match_hit;
  assign stat.free_hit   = free_hit;
  assign stat.exp_any    = (exp_cnt != '0);
  assign stat.exp_last   = (exp_cnt == CNT_BITS'(1));

endmodule

@@ rtl/multi_timer_expiry_queue.sv @@
// Top level of the multi-timer expiry queue: sequencer plus slot datapath.
// Every step is one walk over the slots, its length set by the single read port
// of the slot store. Arm of a new or unknown timer,
// a full bank and a quiet tick: one walk. Re-arm or cancel: two walks. A tick
// that fires k timers: k+2 walks, one result every walk. One item at a time.
// Synchronous reset empties the bank at once; results cannot be stalled.
module multi_timer_expiry_queue #(
  parameter int TIMER_SLOTS = mtq_pkg::DEF_TIMER_SLOTS,
  parameter int ID_BITS     = mtq_pkg::DEF_ID_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mtq_pkg::in_item_t  request,
  output logic               result_valid,
  output mtq_pkg::out_item_t result
);

  // Controller and datapath talk only through these two bundles.
  mtq_pkg::mtq_cmd_t  cmd;
  mtq_pkg::mtq_stat_t stat;

  // The controller walks the states:
  //   arm  : scan (match, first free slot, count) -> optional rank fix-up
  //   tick : age (mark expired, subtract) -> pick rounds -> closing rank fix-up
  // Each pick round closes up ranks behind the timer fired last and searches
  // for the next: smallest remaining time before ageing, oldest rank on ties.
  mtq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (request.mode),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the slot store (id, remaining time, rank), the used
  // and expired flags in flops, and the one-cycle result register.
  mtq_dp #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

@@ tb/sv/multi_timer_expiry_queue_tb.sv @@
// Self-checking testbench for the multi-timer expiry queue: directed and random items.
module multi_timer_expiry_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mtq_pkg::*;

  localparam int SLOTS       = DEF_TIMER_SLOTS;
  localparam int RANK_W      = $clog2(SLOTS);
  // A full tick runs SLOTS+2 walks.
  localparam int WALK_CYCLES = SLOTS + 2;
  localparam int DRAIN_WAIT  = 2 * WALK_CYCLES + 4;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  request = '0;
  logic      result_valid;
  out_item_t result;

  // Shadow copy of the timer bank, kept in step with accepted items.
  logic              bank_used [SLOTS];
  logic [7:0]        bank_id   [SLOTS];
  logic [DELAY_W-1:0] bank_left [SLOTS];
  logic [RANK_W-1:0] bank_rank [SLOTS];

  out_item_t awaited_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        burst_left = 0;

  multi_timer_expiry_queue uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
  );

  always #5 clk = ~clk;

  // Drop slot s from the arming order; younger timers move up one rank.
  function automatic void close_rank(int s);
    for (int i = 0; i < SLOTS; i++) begin
      if (bank_used[i] && i != s && bank_rank[i] > bank_rank[s]) begin
        bank_rank[i] = bank_rank[i] - 1'b1;
      end
    end
  endfunction

  // Applies one accepted item to the shadow bank and queues the results it
  // should give: one ack or full status for an arm, the fired timers (or one ack if none fires) for a tick.
  function automatic void predict_timer_events(in_item_t it);
    int                 n;
    int                 hit;
    int                 best;
    int                 fired;
    logic               due   [SLOTS];
    logic [DELAY_W-1:0] prior [SLOTS];
    logic [DELAY_W-1:0] elapsed_ext;
    out_item_t          r;
    n = 0;
    hit = -1;
    fired = 0;
    r = '0;
    r.last = 1'b1;
    r.status = STATUS_OK;
    if (it.mode == MODE_ARM) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (bank_used[i]) n++;
      end
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (bank_used[i] && bank_id[i] == it.timer_id) hit = i;
      end
      if (hit >= 0) begin
        // Re-arm or cancel of a timer that is present.
        close_rank(hit);
        if (it.delay_us == '0) begin
          bank_used[hit] = 1'b0;
          bank_rank[hit] = '0;
        end else begin
          bank_left[hit] = it.delay_us;
          bank_rank[hit] = RANK_W'(n - 1);
        end
      end else if (it.delay_us != '0) begin
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!bank_used[i]) hit = i;
        end
        if (hit < 0) begin
          r.status = STATUS_FULL;
        end else begin
          bank_used[hit] = 1'b1;
          bank_id[hit]   = it.timer_id;
          bank_left[hit] = it.delay_us;
          bank_rank[hit] = RANK_W'(n);
        end
      end
      awaited_results.push_back(r);
    end else begin
      elapsed_ext = DELAY_W'(it.elapsed_us);
      for (int i = 0; i < SLOTS; i++) begin
        due[i] = 1'b0;
        prior[i] = bank_left[i];
        if (bank_used[i]) begin
          if (bank_left[i] <= elapsed_ext) begin
            due[i] = 1'b1;
            bank_left[i] = '0;
          end else begin
            bank_left[i] = bank_left[i] - elapsed_ext;
          end
        end
      end
      // Most overdue first; equal times go in arming order.
      forever begin
        best = -1;
        for (int i = 0; i < SLOTS; i++) begin
          if (due[i] && (best < 0 || prior[i] < prior[best] ||
              (prior[i] == prior[best] && bank_rank[i] < bank_rank[best]))) begin
            best = i;
          end
        end
        if (best < 0) break;
        r = '0;
        r.fired_valid = 1'b1;
        r.fired_id = bank_id[best];
        r.status = STATUS_OK;
        awaited_results.push_back(r);
        fired++;
        due[best] = 1'b0;
        close_rank(best);
        bank_used[best] = 1'b0;
        bank_rank[best] = '0;
      end
      if (fired == 0) begin
        r = '0;
        r.last = 1'b1;
        awaited_results.push_back(r);
      end else begin
        awaited_results[awaited_results.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic in_item_t arm_item(logic [7:0] id, logic [DELAY_W-1:0] delay);
    in_item_t it;
    it.mode = MODE_ARM;
    it.timer_id = id;
    it.delay_us = delay;
    it.elapsed_us = $urandom;   // ignored on arm
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [ELAPSED_W-1:0] elapsed);
    in_item_t it;
    it.mode = MODE_TICK;
    it.timer_id = 8'($urandom);  // ignored on tick
    it.delay_us = {8'($urandom), 32'($urandom)};
    it.elapsed_us = elapsed;
    return it;
  endfunction

  // Offers one item and waits for its acceptance. Start stays high across
  // a burst; at the end of a burst the sender goes quiet for a random gap.
  task automatic send_item(input in_item_t it);
    request <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_events(it);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Stop offering items and let every queued result come out.
  task automatic settle();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Empty bank: quiet ticks at both extremes of elapsed time and a cancel of
  // an identifier that is not there.
  task automatic test_quiet_bank();
    send_item(tick_item('0));
    send_item(tick_item('1));
    send_item(arm_item(8'h5A, '0));
    settle();
  endtask

  // Extremes of identifier and delay; a zero tick fires nothing, a tick equal
  // to a remaining time fires it.
  task automatic test_field_extremes();
    send_item(arm_item(8'h00, 40'd1));
    send_item(arm_item(8'hFF, '1));
    send_item(arm_item(8'hAA, 40'd5));
    send_item(tick_item('0));
    send_item(tick_item(32'd5));
    send_item(arm_item(8'hFF, '0));
    settle();
  endtask

  // Re-arm makes a timer the newest, cancel closes the ranks, ties fire in
  // arming order and the most overdue timer fires first.
  task automatic test_rearm_and_order();
    send_item(arm_item(8'd10, 40'd100));
    send_item(arm_item(8'd11, 40'd100));
    send_item(arm_item(8'd12, 40'd100));
    send_item(arm_item(8'd10, 40'd100));
    send_item(arm_item(8'd11, '0));
    send_item(arm_item(8'd21, 40'd30));
    send_item(tick_item('1));
    settle();
  endtask

  // Fill all slots, try one more, then re-arm and cancel while full and
  // flush the bank with two ticks.
  task automatic test_full_bank();
    for (int i = 0; i < SLOTS; i++) begin
      send_item(arm_item(8'(8'h30 + i), 40'(1000 - i * 37)));
    end
    send_item(arm_item(8'hC3, 40'd7));
    send_item(arm_item(8'hC4, '0));
    send_item(arm_item(8'h30, 40'd1));
    send_item(tick_item(32'd500));
    send_item(tick_item('1));
    settle();
  endtask

  // Mostly well-formed traffic on a small pool of identifiers so that
  // re-arms, cancels, full banks and multi-timer ticks happen often; the
  // rest is random identifiers and wide values.
  task automatic test_random_traffic(int count);
    in_item_t it;
    logic [7:0] id;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 23) * 11);
      if (pick < 35) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) it = tick_item('0);
        else if (pick == 1) it = tick_item($urandom);
        else it = tick_item(32'($urandom_range(0, 800)));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) it = arm_item(id, '0);
        else if (pick == 1) it = arm_item(id, {8'($urandom), 32'($urandom)});
        else it = arm_item(id, 40'($urandom_range(1, 2000)));
      end
      send_item(it);
    end
    settle();
  endtask

  // Result checker: every strobe is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %p", $time, result);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (result.fired_valid !== want.fired_valid) begin
          $display("%0t: fired_valid expected %0b, got %0b",
                   $time, want.fired_valid, result.fired_valid);
          mismatch_count++;
        end
        if (result.fired_id !== want.fired_id) begin
          $display("%0t: fired_id expected %0d, got %0d", $time, want.fired_id, result.fired_id);
          mismatch_count++;
        end
        if (result.last !== want.last) begin
          $display("%0t: last expected %0b, got %0b", $time, want.last, result.last);
          mismatch_count++;
        end
        if (result.status !== want.status) begin
          $display("%0t: status expected %0b, got %0b", $time, want.status, result.status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      bank_used[i] = 1'b0;
      bank_id[i]   = '0;
      bank_left[i] = '0;
      bank_rank[i] = '0;
    end
    burst_left = $urandom_range(0, 12);
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_quiet_bank();
    test_field_extremes();
    test_rearm_and_order();
    test_full_bank();
    for (int round = 0; round < 4; round++) begin
      test_random_traffic(32);
    end

    // Every walk has finished after settle(); DRAIN_WAIT is a margin before the verdict.
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
